>>> hw/rtl/krev_pkg.sv
// Shared types and constants for the k-group reverse unit.
// No dependencies; imported by k_group_reverse_unit.
package krev_pkg;

	// Depth of the group buffer and the width of its address.
	localparam int MAX_GROUP = 16;
	localparam int ADDR_W    = $clog2(MAX_GROUP);
	localparam int CNT_W     = ADDR_W + 1;

	// Width of the group size register and its value after reset.
	localparam int           SIZE_W     = 5;
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(2);

	// One input word: a list element and the end-of-list flag.
	typedef struct packed {
		logic signed [31:0] value;
		logic               end_of_list;
	} krev_in_t;

	// One output word: a reordered element with its run and list flags.
	typedef struct packed {
		logic signed [31:0] value_res;
		logic               run_last;
		logic               list_end;
	} krev_out_t;

	// Sequencer states, one-hot.
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RD   = 3'b010,
		S_OUT  = 3'b100
	} krev_state_t;

endpackage

>>> hw/rtl/k_group_reverse_unit.sv
// Top level of the k-group reverse unit: group buffer memory and run sequencer.
// Depends on krev_pkg for the word types, buffer depth and state encoding.
//
// The unit takes list elements into a 16-entry group buffer. An element that
// completes nothing is taken while the unit stays idle, and the next word is
// accepted in the cycle after. When an element fills a group (group_size
// elements held) the held elements leave newest first; when an element
// carries end_of_list before a group is full, the held elements leave in
// arrival order. For each word of such a run the unit makes one read of the
// single buffer port followed by a load of the output register, and the load
// waits while the sink holds out_ready low. No input word is accepted
// while a run is being read out; the last word of a run may still wait in the
// output register while the next input word is taken. A group_size of 0 acts
// as 1 and sizes above 16 act as 16. Write group_size only while idle.
module k_group_reverse_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [krev_pkg::SIZE_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  krev_pkg::krev_in_t            in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output krev_pkg::krev_out_t           out_data
);
	import krev_pkg::*;

	logic [31:0]        mem [MAX_GROUP];
	logic [31:0]        rd_q;

	krev_state_t        state_q;
	logic [SIZE_W-1:0]  size_q;
	logic [CNT_W-1:0]   fill_q;
	logic [CNT_W-1:0]   n_q;
	logic [ADDR_W-1:0]  k_q;
	logic               rev_q;
	logic               last_q;
	logic               out_valid_q;
	krev_out_t          out_q;

	logic [CNT_W-1:0]   eff_size;
	logic [ADDR_W-1:0]  wr_idx;
	logic [CNT_W-1:0]   next_fill;
	logic               in_fire;
	logic               emit;
	logic               full_group;
	logic [CNT_W-1:0]   n_m1;
	logic [CNT_W-1:0]   rev_idx;
	logic [ADDR_W-1:0]  rd_addr;
	logic               tail;
	logic               out_free;

	// Clamp the group size to 1..MAX_GROUP.
	always_comb begin
		if (size_q == '0) begin
			eff_size = CNT_W'(1);
		end else if (CNT_W'(size_q) > CNT_W'(MAX_GROUP)) begin
			eff_size = CNT_W'(MAX_GROUP);
		end else begin
			eff_size = CNT_W'(size_q);
		end
	end

	// Decide where the new word goes and whether it releases a run.
	assign in_ready   = (state_q == S_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign wr_idx     = (fill_q >= CNT_W'(MAX_GROUP)) ? '0 : fill_q[ADDR_W-1:0];
	assign next_fill  = CNT_W'(wr_idx) + CNT_W'(1);
	assign full_group = (next_fill >= eff_size);
	assign emit       = full_group || in_data.end_of_list;

	// Address of the k-th word of the run.
	assign n_m1    = n_q - CNT_W'(1);
	assign rev_idx = n_m1 - CNT_W'(k_q);
	assign rd_addr = rev_q ? rev_idx[ADDR_W-1:0] : k_q;
	assign tail    = (CNT_W'(k_q) == n_m1);

	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Group buffer: write on accept, registered read while draining.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mem[wr_idx] <= in_data.value;
		end
		if (state_q == S_RD) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Load the output register from the buffer read.
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			out_q.value_res <= rd_q;
			out_q.run_last  <= tail;
			out_q.list_end  <= tail && last_q;
		end
	end

	// Sequence accept, read and output of each run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			size_q      <= SIZE_RESET;
			fill_q      <= '0;
			n_q         <= '0;
			k_q         <= '0;
			rev_q       <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				size_q <= cfg_data;
			end
			// Raise valid when a word is loaded, drop it once taken
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (emit) begin
							n_q     <= next_fill;
							rev_q   <= full_group;
							last_q  <= in_data.end_of_list;
							k_q     <= '0;
							fill_q  <= '0;
							state_q <= S_RD;
						end else begin
							fill_q <= next_fill;
						end
					end
				end
				S_RD: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						if (tail) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + ADDR_W'(1);
							state_q <= S_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> tb/tb_k_group_reverse_unit.sv
// Self-checking testbench for k_group_reverse_unit: drives lists of words, predicts the
// reordered word stream and compares every output word field by field.
// Depends on krev_pkg for the word types, group buffer depth and size register width.
module tb_k_group_reverse_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import krev_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int REPORT_MAX    = 10;
	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [SIZE_W-1:0] cfg_data;
	logic              in_valid;
	logic              in_ready;
	krev_in_t          in_data;
	logic              out_valid;
	logic              out_ready = 1'b0;
	krev_out_t         out_data;

	// Mirror of the unit: held elements, fill level and programmed group size
	logic signed [31:0] held_words [MAX_GROUP];
	int unsigned        held_count;
	logic [SIZE_W-1:0]  group_size_reg;
	krev_out_t          expected_words [$];

	int mismatch_count = 0;
	int cycle_count = 0;
	int send_idle_pct;
	int recv_stall_pct;

	k_group_reverse_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #1 clk = ~clk;

	// Stall the output side at random
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_k_group_reverse_unit failed");
			$finish;
		end
	end

	function automatic void log_mismatch(string tag, krev_out_t want, krev_out_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX) begin
			$write("%s: expected value_res=%0d run_last=%0b list_end=%0b, ",
				tag, want.value_res, want.run_last, want.list_end);
			$display("got value_res=%0d run_last=%0b list_end=%0b",
				got.value_res, got.run_last, got.list_end);
		end
	endfunction

	// Compare each accepted output word with the oldest expected word
	always @(posedge clk) begin
		krev_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				log_mismatch("unexpected word", '0, out_data);
			end else begin
				want = expected_words.pop_front();
				if (out_data.value_res !== want.value_res || out_data.run_last !== want.run_last
						|| out_data.list_end !== want.list_end)
					log_mismatch("word mismatch", want, out_data);
			end
		end
	end

	// Hold one element; once a group fills or the list ends, queue the run it releases
	function automatic void predict_runs(krev_in_t w);
		int unsigned span;
		int unsigned n;
		bit          flip;
		krev_out_t   e;
		if (group_size_reg == 0)
			span = 1;
		else if (group_size_reg > MAX_GROUP)
			span = MAX_GROUP;
		else
			span = group_size_reg;
		if (held_count >= MAX_GROUP)
			held_count = 0;
		held_words[held_count] = w.value;
		held_count++;
		if (held_count >= span)
			flip = 1'b1;
		else if (w.end_of_list)
			flip = 1'b0;
		else
			return;
		n = held_count;
		for (int unsigned k = 0; k < n; k++) begin
			e.value_res = held_words[flip ? (n - 1 - k) : k];
			e.run_last  = (k + 1 == n);
			e.list_end  = (k + 1 == n) && w.end_of_list;
			expected_words.push_back(e);
		end
		held_count = 0;
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(15))
			0:       return VAL_MIN;
			1:       return VAL_MAX;
			2:       return 32'sd0;
			3:       return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// Mostly small groups, now and then the extremes and out-of-range sizes
	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(9))
			0:       return SIZE_W'(1);
			1:       return SIZE_W'(MAX_GROUP);
			2:       return SIZE_W'(0);
			3:       return SIZE_W'(31);
			4:       return SIZE_W'($urandom_range(17, 31));
			default: return SIZE_W'($urandom_range(2, 12));
		endcase
	endfunction

	// Send one element word; valid stays high afterwards unless a gap follows
	task automatic send_word(input logic signed [31:0] v, input logic eol);
		krev_in_t w;
		w.value       = v;
		w.end_of_list = eol;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		predict_runs(w);
	endtask

	// Drop valid and wait until every expected word is out and the unit has settled
	task automatic settle_idle();
		in_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_group_size(input logic [SIZE_W-1:0] size);
		settle_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= size;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		group_size_reg = size;
	endtask

	// Reset size of two: extreme values, a trailing partial group, a one-element list
	task automatic test_reset_size();
		send_word(VAL_MIN, 1'b0);
		send_word(VAL_MAX, 1'b0);
		send_word(32'sd0, 1'b1);
		send_word(-32'sd1, 1'b1);
	endtask

	// Final element completes a full group
	task automatic test_full_group_at_end();
		write_group_size(SIZE_W'(3));
		send_word(32'sd1, 1'b0);
		send_word(32'sd2, 1'b0);
		send_word(32'sd3, 1'b1);
	endtask

	// Size one, size zero, and a size past the buffer depth with a list shorter than it
	task automatic test_size_limits();
		write_group_size(SIZE_W'(1));
		send_word(32'sd5, 1'b0);
		send_word(32'sd6, 1'b1);
		write_group_size(SIZE_W'(0));
		send_word(32'sd7, 1'b0);
		send_word(32'sd8, 1'b1);
		write_group_size(SIZE_W'(31));
		send_word(32'sd9, 1'b0);
		send_word(32'sd10, 1'b1);
	endtask

	// Shrink the group size while elements are held
	task automatic test_shrink_while_held();
		write_group_size(SIZE_W'(5));
		send_word(32'sd11, 1'b0);
		send_word(32'sd12, 1'b0);
		send_word(32'sd13, 1'b0);
		write_group_size(SIZE_W'(2));
		send_word(32'sd14, 1'b1);
	endtask

	// Random lists under random sizes, some resized mid-list, some paused until drained
	task automatic test_random_lists(input int n_items);
		int sent;
		int lists;
		int len;
		int cut;
		sent = 0;
		while (sent < n_items) begin
			write_group_size(pick_size());
			lists = $urandom_range(1, 4);
			for (int l = 0; l < lists; l++) begin
				len = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
				// Cut the last list short so the batch stays within its word budget
				if (len > n_items - sent)
					len = n_items - sent;
				cut = ($urandom_range(5) == 0) ? $urandom_range(1, len) : 0;
				for (int i = 0; i < len; i++) begin
					if (i == cut)
						write_group_size(pick_size());
					else if (i != 0 && $urandom_range(19) == 0)
						settle_idle();
					send_word(pick_value(), i == len - 1);
					sent++;
				end
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		cfg_data       = '0;
		in_valid       = 1'b0;
		in_data        = '0;
		held_count     = 0;
		group_size_reg = SIZE_RESET;
		send_idle_pct  = 29;
		recv_stall_pct = 74;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_size();
		test_full_group_at_end();
		test_size_limits();
		test_shrink_while_held();

		test_random_lists(93);
		send_idle_pct  = 74;
		recv_stall_pct = 29;
		test_random_lists(93);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		test_random_lists(93);

		settle_idle();
		if (mismatch_count == 0 && expected_words.size() == 0) begin
			$display("tb_k_group_reverse_unit passed");
		end else begin
			if (expected_words.size() != 0)
				$display("%0d expected words never arrived", expected_words.size());
			$display("tb_k_group_reverse_unit failed");
		end
		$finish;
	end

endmodule
